### rtl/core/sctq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike-confirming temperature qualifier package
// Shared widths, reset values, register indexes and the records that travel
// between the front, the queue and the back of the qualifier.
// ----------------------------------------------------------------------------
package sctq_pkg;

  localparam int TEMP_BITS       = 12;
  localparam int LIM_BITS        = 11;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = TEMP_BITS;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 16;
  localparam int TRIES_W         = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = 1;
  localparam int QUEUE_CNT_W     = 2;

  localparam int WINDOW_LEN_DEF  = 5;
  localparam int MAX_TRIES_DEF   = 3;

  // Register reset values, 1/16 degree units.
  localparam logic [LIM_BITS-1:0]         JUMP_LIMIT_RST    = 11'd160;
  localparam logic [LIM_BITS-1:0]         CONFIRM_LIMIT_RST = 11'd32;
  localparam logic signed [TEMP_BITS-1:0] VALID_FLOOR_RST   = -12'sd800;
  localparam logic signed [TEMP_BITS-1:0] FAIL_CEILING_RST  = -12'sd1920;
  localparam logic signed [TEMP_BITS-1:0] POWER_ON_CODE_RST = 12'sd1360;
  localparam logic signed [TEMP_BITS-1:0] LOST_CODE_RST     = -12'sd2032;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_LIMIT    = 3'd0,
    REG_CONFIRM_LIMIT = 3'd1,
    REG_VALID_FLOOR   = 3'd2,
    REG_FAIL_CEILING  = 3'd3,
    REG_POWER_ON_CODE = 3'd4,
    REG_LOST_CODE     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [LIM_BITS-1:0]         jump_limit;
    logic [LIM_BITS-1:0]         confirm_limit;
    logic signed [TEMP_BITS-1:0] valid_floor;
    logic signed [TEMP_BITS-1:0] fail_ceiling;
    logic signed [TEMP_BITS-1:0] power_on_code;
    logic signed [TEMP_BITS-1:0] lost_code;
  } cfg_t;

  // One classified reading on its way from the front to the back.
  typedef struct packed {
    logic signed [TEMP_BITS-1:0] reading;
    logic                        skip;
  } item_t;

endpackage

### rtl/core/spike_confirming_temp_qualifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike-confirming temperature qualifier, top level
// Qualifies raw sensor readings against a short history window and reports
// one temperature per measurement, or the lost code after repeated misses.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake                    Payload
// s_axis     in         s_axis_tvalid/s_axis_tready  one raw reading
// m_axis     out        m_axis_tvalid/m_axis_tready  one measurement result
// cfg        in         cfg_valid/cfg_ready          register index and data
//
// One reading is taken per clock cycle while the queue has room. The back
// end decides a reading combinationally from the window registers; a
// two-entry queue separates it from the input, and the output register is
// refilled in the same cycle in which its result is taken. A stalled output
// stops the back end only, and the input keeps flowing until the queue holds
// two readings. Reset is synchronous and needs no clearing pass: the window
// comes up holding the lost code, so an unskipped first reading recovers.
// ----------------------------------------------------------------------------
module spike_confirming_temp_qualifier_top #(
  parameter int WINDOW_LEN = sctq_pkg::WINDOW_LEN_DEF,
  parameter int MAX_TRIES  = sctq_pkg::MAX_TRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream. tdata: reading [11:0], zeros [15:12].
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sctq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result stream. tdata: temperature [11:0], tries_used [13:12], zeros [15:14].
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sctq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: valid_res [0].
  output logic [0:0]                        m_axis_tuser,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sctq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sctq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sctq_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  push_ready;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  // Register file for the thresholds and codes.
  sctq_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The front marks readings that are sensor failures or power-on values.
  sctq_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg           (cfg),
    .push          (push),
    .push_item     (push_item),
    .push_ready    (push_ready)
  );

  sctq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  // The back end runs the measurement and owns the window.
  sctq_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .MAX_TRIES  (MAX_TRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // The back end never takes an item from an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");

  // A waiting result is never overwritten by a newly decided reading.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !pop)
    else $error("back end advanced over a held result");

  // A lost result always reports the full number of tries.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[TEMP_BITS+TRIES_W-1:TEMP_BITS] == TRIES_W'(MAX_TRIES)))
    else $error("lost result with short try count");

  // A transaction taken into the queue leaves it holding at least one item.
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> q_valid)
    else $error("accepted reading did not reach the queue");

endmodule

### rtl/core/sctq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Qualifier configuration registers
// Holds the six thresholds and codes, written through the config channel.
// ----------------------------------------------------------------------------
module sctq_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sctq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sctq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sctq_pkg::cfg_t                   cfg
);
  import sctq_pkg::*;

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_limit    <= JUMP_LIMIT_RST;
      cfg.confirm_limit <= CONFIRM_LIMIT_RST;
      cfg.valid_floor   <= VALID_FLOOR_RST;
      cfg.fail_ceiling  <= FAIL_CEILING_RST;
      cfg.power_on_code <= POWER_ON_CODE_RST;
      cfg.lost_code     <= LOST_CODE_RST;
    end else if (wr) begin
      case (reg_idx_t'(cfg_index))
        REG_JUMP_LIMIT:    cfg.jump_limit    <= cfg_data[LIM_BITS-1:0];
        REG_CONFIRM_LIMIT: cfg.confirm_limit <= cfg_data[LIM_BITS-1:0];
        REG_VALID_FLOOR:   cfg.valid_floor   <= $signed(cfg_data[TEMP_BITS-1:0]);
        REG_FAIL_CEILING:  cfg.fail_ceiling  <= $signed(cfg_data[TEMP_BITS-1:0]);
        REG_POWER_ON_CODE: cfg.power_on_code <= $signed(cfg_data[TEMP_BITS-1:0]);
        REG_LOST_CODE:     cfg.lost_code     <= $signed(cfg_data[TEMP_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/sctq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Qualifier front end
// Takes readings from the input stream and marks sensor-failure and
// power-on values so the back end can skip them.
// ----------------------------------------------------------------------------
module sctq_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sctq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  sctq_pkg::cfg_t                    cfg,
  output logic                              push,
  output sctq_pkg::item_t                   push_item,
  input  logic                              push_ready
);
  import sctq_pkg::*;

  logic signed [TEMP_BITS-1:0] rd;

  assign rd            = $signed(s_axis_tdata[TEMP_BITS-1:0]);
  assign s_axis_tready = push_ready;
  assign push          = s_axis_tvalid && push_ready;

  always_comb begin
    push_item.reading = rd;
    push_item.skip    = (rd <= cfg.fail_ceiling) || (rd == cfg.power_on_code);
  end

endmodule

### rtl/core/sctq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Qualifier item queue
// Two-entry register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sctq_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sctq_pkg::item_t  push_item,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output sctq_pkg::item_t  pop_item
);
  import sctq_pkg::*;

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  assign push_ready = (fill != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/core/sctq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Qualifier back end
// Owns the history window and the measurement state, decides each reading
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module sctq_back #(
  parameter int WINDOW_LEN = sctq_pkg::WINDOW_LEN_DEF,
  parameter int MAX_TRIES  = sctq_pkg::MAX_TRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sctq_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  input  sctq_pkg::item_t                   q_item,
  output logic                              pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sctq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [0:0]                        m_axis_tuser
);
  import sctq_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = TEMP_BITS + CNT_W;
  localparam int PROD_W = TEMP_BITS + CNT_W + 1;
  localparam int DIFF_W = PROD_W + 1;
  localparam int LIM_W  = LIM_BITS + CNT_W;
  localparam int RING_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TRY_W  = $clog2(MAX_TRIES + 1);
  localparam int PAD_W  = OUT_TDATA_W - TEMP_BITS - TRIES_W;

  logic signed [TEMP_BITS-1:0] window [WINDOW_LEN];
  logic [RING_W-1:0]           ring;
  logic [TRY_W-1:0]            try_count;
  logic signed [TEMP_BITS-1:0] first_value;

  logic signed [TEMP_BITS-1:0] temperature;
  logic                        valid_res;
  logic [TRIES_W-1:0]          tries_used;

  logic signed [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]            cnt;
  logic signed [PROD_W-1:0]    prod;
  logic signed [DIFF_W-1:0]    jdiff;
  logic [DIFF_W-1:0]           jmag;
  logic [LIM_W-1:0]            jlim;
  logic signed [TEMP_BITS:0]   cdiff;
  logic [TEMP_BITS:0]          cmag;
  logic                        is_first;
  logic                        jump_ok;
  logic                        conf_ok;
  logic                        ok;
  logic                        refill;
  logic                        lost;
  logic                        emit;
  logic [TRY_W-1:0]            tries_new;
  logic [TRY_W+TRIES_W-1:0]    tries_ext;
  logic signed [TEMP_BITS-1:0] r;

  assign r = q_item.reading;

  // Mean of the valid window entries, kept as a sum and a count.
  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (window[i] > cfg.valid_floor) begin
        sum = sum + SUM_W'(window[i]);
        cnt = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    is_first  = (try_count == '0);
    prod      = $signed({1'b0, cnt}) * r;
    jdiff     = DIFF_W'(prod) - DIFF_W'(sum);
    jmag      = jdiff[DIFF_W-1] ? DIFF_W'(-jdiff) : DIFF_W'(jdiff);
    jlim      = LIM_W'(cfg.jump_limit) * LIM_W'(cnt);
    jump_ok   = (jmag < DIFF_W'(jlim));
    cdiff     = (TEMP_BITS+1)'(r) - (TEMP_BITS+1)'(first_value);
    cmag      = cdiff[TEMP_BITS] ? (TEMP_BITS+1)'(-cdiff) : (TEMP_BITS+1)'(cdiff);
    conf_ok   = (cmag < (TEMP_BITS+1)'(cfg.confirm_limit));
    if (q_item.skip) begin
      ok = 1'b0;
    end else if (is_first) begin
      ok = (cnt == '0) || jump_ok;
    end else begin
      ok = conf_ok;
    end
    // Recovery on an empty window and confirmation of a jump both refill.
    refill    = ok && (!is_first || (cnt == '0));
    tries_new = try_count + 1'b1;
    lost      = !ok && (tries_new >= TRY_W'(MAX_TRIES));
    emit      = ok || lost;
    tries_ext = {{TRIES_W{1'b0}}, tries_new};
  end

  assign pop = q_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= LOST_CODE_RST;
      end
      ring        <= '0;
      try_count   <= '0;
      first_value <= LOST_CODE_RST;
    end else if (pop) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if (ok && (refill || (ring == RING_W'(i)))) begin
          window[i] <= r;
        end else if (lost) begin
          window[i] <= cfg.lost_code;
        end
      end
      if (ok) begin
        ring <= (ring == RING_W'(WINDOW_LEN - 1)) ? '0 : ring + 1'b1;
      end
      try_count <= emit ? '0 : tries_new;
      if (is_first) begin
        first_value <= q_item.skip ? cfg.lost_code : r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (pop && emit) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      temperature <= ok ? r : cfg.lost_code;
      valid_res   <= ok;
      tries_used  <= tries_ext[TRIES_W-1:0];
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, tries_used, temperature};
  assign m_axis_tuser = valid_res;

endmodule
